>>> design/fbl_pkg.sv
// shared types and constants for the fault blink code led block
// no dependencies; imported by every module of the block except fbl_rem
`default_nettype none

package fbl_pkg;

    localparam int unsigned N_UNITS = 5;

    localparam logic [2:0] FIRST_CODE = 3'd2;
    localparam logic [2:0] LAST_CODE  = 3'd6;

    localparam logic [16:0] HB_FIRST_END    = 17'd80;
    localparam logic [16:0] HB_SECOND_START = 17'd150;
    localparam logic [16:0] HB_SECOND_END   = 17'd230;

    // configuration register indexes
    localparam logic [2:0] REG_HB_ENABLED = 3'd0;
    localparam logic [2:0] REG_HB_PERIOD  = 3'd1;
    localparam logic [2:0] REG_FLASH_ON   = 3'd2;
    localparam logic [2:0] REG_FLASH_OFF  = 3'd3;
    localparam logic [2:0] REG_CODE_GAP   = 3'd4;

    typedef struct packed {
        logic        hb_enabled;
        logic [15:0] hb_period;
        logic [15:0] flash_on;
        logic [15:0] flash_off;
        logic [15:0] code_gap;
    } fbl_cfg_t;

    // one classified update: time, number of failed units and their codes in order
    typedef struct packed {
        logic [31:0]          now;
        logic [2:0]           count;
        logic [N_UNITS-1:0][2:0] codes;
    } fbl_item_t;

endpackage

`default_nettype wire

>>> design/fbl_front.sv
// front end: accepts updates and builds the ordered list of failed unit codes
// depends on fbl_pkg
`default_nettype none

module fbl_front
    import fbl_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic [31:0]         in_now,
    input  wire logic [N_UNITS-1:0]  in_ok,
    output logic           out_valid,
    input  wire logic      out_ready,
    output fbl_item_t      out_item
);

    logic      valid_reg;
    fbl_item_t item_reg;
    fbl_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        logic [2:0] cnt;
        cnt = 3'd0;
        item_next.now   = in_now;
        item_next.codes = '0;
        for (int i = 0; i < N_UNITS; i++) begin
            if (!in_ok[i]) begin
                item_next.codes[cnt] = FIRST_CODE + 3'(i);
                cnt = cnt + 3'd1;
            end
        end
        item_next.count = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

>>> design/fbl_fifo.sv
// short queue of classified updates between front and back
// depends on fbl_pkg
`default_nettype none

module fbl_fifo
    import fbl_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    input  wire fbl_item_t wr_item,
    output logic           rd_valid,
    input  wire logic      rd_ready,
    output fbl_item_t      rd_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fbl_item_t      mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    fill_reg;
    logic           do_wr;
    logic           do_rd;

    assign wr_ready = (fill_reg != (AW+1)'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd) begin
                fill_reg <= fill_reg + (AW+1)'(1);
            end else if (do_rd && !do_wr) begin
                fill_reg <= fill_reg - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

>>> design/fbl_rem.sv
// shared remainder unit: 32-bit dividend by 17-bit divisor, one bit per cycle
// no dependencies
`default_nettype none

module fbl_rem (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [16:0] divisor,
    output logic             done,
    output logic [16:0]      rem
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dvd_reg;
    logic [16:0] div_reg;
    logic [16:0] rem_reg;
    logic [17:0] trial;
    logic [17:0] rem_next;

    assign done = done_reg;
    assign rem  = rem_reg;

    // remainder stays below the divisor, so the shifted value fits 18 bits
    always_comb begin
        trial = {rem_reg, dvd_reg[31]};
        rem_next = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next[16:0];
        end
    end

endmodule

`default_nettype wire

>>> design/fbl_back.sv
// back end: heartbeat and blink code sequencing, holds code position state
// depends on fbl_pkg and fbl_rem
`default_nettype none

module fbl_back
    import fbl_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire fbl_cfg_t  cfg,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire fbl_item_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic           out_led
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  state_reg;
    logic [2:0]  fp_reg;
    logic [31:0] start_reg;
    fbl_item_t   item_reg;
    logic        faulted_reg;
    logic [2:0]  code_reg;
    logic [16:0] unit_reg;
    logic [31:0] pos_reg;
    logic [19:0] flashes_reg;
    logic [20:0] cycle_reg;
    logic        led_reg;
    logic        out_valid_reg;
    logic        out_led_reg;

    logic        rem_start;
    logic [31:0] rem_dividend;
    logic [16:0] rem_divisor;
    logic        rem_done;
    logic [16:0] rem_value;

    logic [2:0]  fp_eff;
    logic [2:0]  fp_inc;
    logic        hb_lit;
    logic        slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_led   = out_led_reg;
    assign slot_free = !out_valid_reg || out_ready;

    assign fp_eff = (fp_reg >= item_reg.count) ? 3'd0 : fp_reg;
    assign fp_inc = fp_reg + 3'd1;

    assign hb_lit = (rem_value < HB_FIRST_END) ||
                    ((rem_value > HB_SECOND_START) && (rem_value < HB_SECOND_END));

    // healthy items divide the time by the period, faulted ones the position by the unit
    always_comb begin
        rem_start    = 1'b0;
        rem_dividend = item_reg.now;
        rem_divisor  = (cfg.hb_period == '0) ? 17'd1 : {1'b0, cfg.hb_period};
        if (state_reg == S_PREP && item_reg.count == '0) begin
            rem_start = 1'b1;
        end else if (state_reg == S_DEC && faulted_reg) begin
            rem_dividend = pos_reg;
            rem_divisor  = unit_reg;
            rem_start    = (pos_reg < {11'd0, cycle_reg}) &&
                           (pos_reg < {12'd0, flashes_reg}) && (unit_reg != '0);
        end
    end

    fbl_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .done     (rem_done),
        .rem      (rem_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fp_reg        <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (item_reg.count == '0) begin
                        state_reg <= S_DIV;
                    end else begin
                        fp_reg    <= fp_eff;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (pos_reg >= {11'd0, cycle_reg}) begin
                        start_reg <= item_reg.now;
                        fp_reg    <= (fp_inc == item_reg.count) ? 3'd0 : fp_inc;
                        state_reg <= S_OUT;
                    end else if (rem_start) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (rem_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (slot_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && in_valid) begin
            item_reg <= in_item;
        end
        if (state_reg == S_PREP) begin
            faulted_reg <= (item_reg.count != '0);
            code_reg    <= item_reg.codes[fp_eff];
            unit_reg    <= {1'b0, cfg.flash_on} + {1'b0, cfg.flash_off};
            pos_reg     <= item_reg.now - start_reg;
        end
        if (state_reg == S_MUL) begin
            flashes_reg <= {17'd0, code_reg} * {3'd0, unit_reg};
        end
        if (state_reg == S_DEC) begin
            led_reg <= 1'b0;
        end
        if (state_reg == S_MUL) begin
            cycle_reg <= {1'b0, {17'd0, code_reg} * {3'd0, unit_reg}} + {5'd0, cfg.code_gap};
        end
        if (state_reg == S_DIV && rem_done) begin
            led_reg <= faulted_reg ? (rem_value < {1'b0, cfg.flash_on})
                                   : (cfg.hb_enabled && hb_lit);
        end
        if (state_reg == S_OUT && slot_free) begin
            out_led_reg <= led_reg;
        end
    end

endmodule

`default_nettype wire

>>> design/fault_blink_code_led_top.sv
// top level of the status led blink code generator
// depends on fbl_pkg, fbl_front, fbl_fifo, fbl_rem and fbl_back
//
// s_ channel: one update per item (time stamp and five health flags).
// m_ channel: one led level per update, in order.
// cfg channel: register writes, always ready; write only while the block is idle.
// An update passes a classifying front stage into a short queue; the back end
// then takes it and runs a sequencer around a shared bit-serial remainder
// unit. A healthy update and a faulted one inside the flash section go through
// the remainder unit on their way to the output register; a faulted update in
// the gap or at a cycle end skips it. The back end takes a new update only
// when it is done with the last one.
// The front keeps accepting while the back works, until the queue is full.
// If the receiver stalls, the result waits in the output register and the
// back holds its next finished result; updates pile up in the queue.
// Reset clears the queue, the code position, the cycle start time and loads
// the configuration defaults (heartbeat on, 2000, 200, 300, 1500 ms).
`default_nettype none

module fault_blink_code_led_top
    import fbl_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // now_ms[31:0], link_ok[32], humidity_sensor_ok[33], gas_sensor_ok[34],
    // pressure_sensor_ok[35], particle_sensor_ok[36], zero fill [39:37]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // led_on[0], zero fill [7:1]
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    fbl_cfg_t  cfg_reg;
    logic      f_valid;
    logic      f_ready;
    fbl_item_t f_item;
    logic      q_valid;
    logic      q_ready;
    fbl_item_t q_item;
    logic      led;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hb_enabled <= 1'b1;
            cfg_reg.hb_period  <= 16'd2000;
            cfg_reg.flash_on   <= 16'd200;
            cfg_reg.flash_off  <= 16'd300;
            cfg_reg.code_gap   <= 16'd1500;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_HB_ENABLED: cfg_reg.hb_enabled <= cfg_wdata[0];
                REG_HB_PERIOD:  cfg_reg.hb_period  <= cfg_wdata;
                REG_FLASH_ON:   cfg_reg.flash_on   <= cfg_wdata;
                REG_FLASH_OFF:  cfg_reg.flash_off  <= cfg_wdata;
                REG_CODE_GAP:   cfg_reg.code_gap   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    fbl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_now    (s_tdata[31:0]),
        .in_ok     (s_tdata[36:32]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    fbl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    fbl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_led   (led)
    );

    assign m_tdata = {7'd0, led};

endmodule

`default_nettype wire
